// ===== src/isqc_pkg.sv =====
// ----------------------------------------------------------------------------
// isqc_pkg
// Shared types and codes for the intersection signal queue controller.
// ----------------------------------------------------------------------------
package isqc_pkg;

    localparam logic [1:0] KIND_ARRIVAL   = 2'd0;
    localparam logic [1:0] KIND_DEPARTURE = 2'd1;
    localparam logic [1:0] KIND_STATUS    = 2'd2;

    localparam logic [1:0] LIGHT_RED   = 2'd0;
    localparam logic [1:0] LIGHT_AMBER = 2'd1;
    localparam logic [1:0] LIGHT_GREEN = 2'd2;

    localparam logic [1:0] REG_GREEN  = 2'd0;
    localparam logic [1:0] REG_AMBER  = 2'd1;
    localparam logic [1:0] REG_ALLRED = 2'd2;
    localparam logic [1:0] REG_SERVE  = 2'd3;

    localparam logic [3:0] MAX_SERVE = 4'd8;
    localparam int         NUM_MOV   = 12;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ARRV  = 7'b0000010,
        ST_TICK  = 7'b0000100,
        ST_RDREQ = 7'b0001000,
        ST_RDOUT = 7'b0010000,
        ST_STAT  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

endpackage

// ===== src/isqc_ram.sv =====
// ----------------------------------------------------------------------------
// isqc_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module isqc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 3072
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/intersection_signal_queue_controller.sv =====
// ----------------------------------------------------------------------------
// intersection_signal_queue_controller
// Two-phase signal sequencer with twelve movement FIFOs in one RAM.
// ----------------------------------------------------------------------------
// arrival: the item is taken in ST_IDLE; ST_ARRV writes the queue RAM and the result register,
//   then ST_OUT; tick outside green: ST_TICK sets the lights, ST_STAT registers the status
// green tick: ST_RDREQ and ST_RDOUT per departure (one RAM read each) plus one ST_RDREQ to close
//   each of the four served movements; up to 32 departures per tick
// one item at a time, output stalls hold the current state; pointers and phase state reset at once,
//   queue RAM contents are not cleared (only entries between head and tail are read)
module intersection_signal_queue_controller #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [1:0]  s_direction,
    input  logic [1:0]  s_turn,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_vehicle_id,
    output logic [3:0]  m_movement,
    output logic        m_accepted,
    output logic [11:0] m_queue_count,
    output logic [15:0] m_wait_time,
    output logic [1:0]  m_ns_light,
    output logic [1:0]  m_ew_light,
    output logic [9:0]  m_ns_remaining,
    output logic [9:0]  m_ew_remaining,
    output logic        m_phase_change,
    output logic        m_last
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int MD = isqc_pkg::NUM_MOV * QUEUE_DEPTH;
    localparam int AW = $clog2(MD);
    localparam logic [PW-1:0] PMAX = PW'(QUEUE_DEPTH - 1);

    isqc_pkg::state_t state_reg, state_next;

    logic [7:0]  green_reg, amber_reg, allred_reg;
    logic [3:0]  serve_reg;
    logic [PW-1:0] head_reg [isqc_pkg::NUM_MOV];
    logic [PW-1:0] tail_reg [isqc_pkg::NUM_MOV];
    logic        axis_reg;
    logic [9:0]  ptick_reg;
    logic [15:0] now_reg, vid_reg;
    logic [1:0]  light_reg [2];
    logic [9:0]  rem_reg [2];

    // request latch
    logic [1:0]  dir_reg, turn_reg;
    // walk over the four served movements: {dir bit, turn bit}, plus pop count
    logic [1:0]  slot_reg;
    logic [3:0]  cnt_reg;
    logic        chg_reg;

    // output register
    logic        ov_reg, olast_reg, oacc_reg, opc_reg;
    logic [1:0]  okind_reg;
    logic [15:0] oid_reg, owait_reg;
    logic [3:0]  omv_reg;
    logic [11:0] ocnt_reg;

    logic [31:0] rd_data;
    logic        wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [31:0] wr_data;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PMAX) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [11:0] occ(input logic [PW-1:0] h, input logic [PW-1:0] t);
        logic [PW:0] d;
        d = (t >= h) ? {1'b0, t} - {1'b0, h}
                     : {1'b0, t} + (PW+1)'(QUEUE_DEPTH) - {1'b0, h};
        return 12'(d);
    endfunction

    isqc_ram #(.WIDTH(32), .DEPTH(MD)) u_ram (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // arrival decode
    logic [3:0]  arr_mv;
    logic        arr_ok;
    logic [PW-1:0] arr_tail_nx;
    assign arr_mv = 4'({2'b0, dir_reg} * 4'd3 + {2'b0, turn_reg});
    assign arr_ok = (turn_reg != 2'd3) &&
                    (wrap_inc(tail_reg[arr_mv]) != head_reg[arr_mv]);
    assign arr_tail_nx = wrap_inc(tail_reg[arr_mv]);

    // served movement of current slot
    logic [1:0]  srv_dir;
    logic [3:0]  srv_mv;
    logic [3:0]  lim;
    logic        srv_empty;
    assign srv_dir = {axis_reg, slot_reg[1]};
    assign srv_mv  = 4'({2'b0, srv_dir} * 4'd3 + (slot_reg[0] ? 4'd2 : 4'd0));
    assign lim     = (serve_reg > isqc_pkg::MAX_SERVE) ? isqc_pkg::MAX_SERVE : serve_reg;
    assign srv_empty = head_reg[srv_mv] == tail_reg[srv_mv];

    // phase decode
    logic [9:0] g_end, a_end, r_end;
    assign g_end = {2'b0, green_reg};
    assign a_end = g_end + {2'b0, amber_reg};
    assign r_end = a_end + {2'b0, allred_reg};
    logic in_green;
    assign in_green = ptick_reg < g_end;

    // saturating countdown of the remaining ticks
    logic [9:0] rem_dec [2];
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            rem_dec[i] = (rem_reg[i] != '0) ? rem_reg[i] - 10'd1 : rem_reg[i];
        end
    end

    assign wr_en   = (state_reg == isqc_pkg::ST_ARRV) && arr_ok;
    assign wr_addr = AW'(arr_mv) * AW'(QUEUE_DEPTH) + AW'(tail_reg[arr_mv]);
    assign wr_data = {vid_reg, now_reg};
    assign rd_addr = AW'(srv_mv) * AW'(QUEUE_DEPTH) + AW'(head_reg[srv_mv]);

    assign s_ready = state_reg == isqc_pkg::ST_IDLE;
    logic out_free;
    assign out_free = !ov_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            isqc_pkg::ST_IDLE: if (s_valid) begin
                state_next = s_req_type ? isqc_pkg::ST_TICK : isqc_pkg::ST_ARRV;
            end
            isqc_pkg::ST_ARRV: if (out_free) state_next = isqc_pkg::ST_OUT;
            isqc_pkg::ST_TICK: begin
                if (in_green) state_next = isqc_pkg::ST_RDREQ;
                else state_next = isqc_pkg::ST_STAT;
            end
            isqc_pkg::ST_RDREQ: begin
                if (cnt_reg < lim && !srv_empty) state_next = isqc_pkg::ST_RDOUT;
                else if (slot_reg == 2'd3) state_next = isqc_pkg::ST_STAT;
            end
            isqc_pkg::ST_RDOUT: if (out_free) state_next = isqc_pkg::ST_RDREQ;
            isqc_pkg::ST_STAT: if (out_free) state_next = isqc_pkg::ST_OUT;
            isqc_pkg::ST_OUT: if (!ov_reg || m_ready) state_next = isqc_pkg::ST_IDLE;
            default: state_next = isqc_pkg::ST_IDLE;
        endcase
    end

    // ST_OUT waits until the final item is taken; ov_reg drops when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= isqc_pkg::ST_IDLE;
            green_reg  <= 8'd8;
            amber_reg  <= 8'd2;
            allred_reg <= 8'd1;
            serve_reg  <= 4'd2;
            axis_reg   <= 1'b0;
            ptick_reg  <= '0;
            now_reg    <= '0;
            vid_reg    <= 16'd1;
            ov_reg     <= 1'b0;
            slot_reg   <= '0;
            cnt_reg    <= '0;
            for (int i = 0; i < isqc_pkg::NUM_MOV; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            for (int i = 0; i < 2; i++) begin
                light_reg[i] <= isqc_pkg::LIGHT_RED;
                rem_reg[i]   <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    isqc_pkg::REG_GREEN:  green_reg  <= cfg_data;
                    isqc_pkg::REG_AMBER:  amber_reg  <= cfg_data;
                    isqc_pkg::REG_ALLRED: allred_reg <= cfg_data;
                    isqc_pkg::REG_SERVE:  serve_reg  <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (ov_reg && m_ready) ov_reg <= 1'b0;
            unique case (state_reg)
                isqc_pkg::ST_IDLE: begin
                    slot_reg <= '0;
                    cnt_reg  <= '0;
                    if (s_valid) begin
                        dir_reg  <= s_direction;
                        turn_reg <= s_turn;
                    end
                end
                isqc_pkg::ST_ARRV: if (out_free) begin
                    vid_reg <= vid_reg + 16'd1;
                    if (arr_ok) tail_reg[arr_mv] <= arr_tail_nx;
                    ov_reg    <= 1'b1;
                    okind_reg <= isqc_pkg::KIND_ARRIVAL;
                    oid_reg   <= vid_reg;
                    omv_reg   <= arr_mv;
                    oacc_reg  <= arr_ok;
                    ocnt_reg  <= (turn_reg == 2'd3) ? 12'd0 :
                                 occ(head_reg[arr_mv], arr_ok ? arr_tail_nx
                                                              : tail_reg[arr_mv]);
                    owait_reg <= '0;
                    opc_reg   <= 1'b0;
                    olast_reg <= 1'b1;
                end
                isqc_pkg::ST_TICK: begin
                    chg_reg <= 1'b0;
                    if (in_green) begin
                        light_reg[axis_reg]  <= isqc_pkg::LIGHT_GREEN;
                        rem_reg[axis_reg]    <= g_end - ptick_reg;
                        light_reg[~axis_reg] <= isqc_pkg::LIGHT_RED;
                        rem_reg[~axis_reg]   <= '0;
                    end else if (ptick_reg < a_end) begin
                        light_reg[axis_reg]  <= isqc_pkg::LIGHT_AMBER;
                        rem_reg[axis_reg]    <= a_end - ptick_reg;
                        light_reg[~axis_reg] <= isqc_pkg::LIGHT_RED;
                        rem_reg[~axis_reg]   <= '0;
                    end else if (ptick_reg < r_end) begin
                        light_reg[0] <= isqc_pkg::LIGHT_RED;
                        light_reg[1] <= isqc_pkg::LIGHT_RED;
                        rem_reg[0]   <= r_end - ptick_reg;
                        rem_reg[1]   <= r_end - ptick_reg;
                    end else begin
                        chg_reg <= 1'b1;
                    end
                end
                isqc_pkg::ST_RDREQ: begin
                    if (!(cnt_reg < lim && !srv_empty)) begin
                        slot_reg <= slot_reg + 2'd1;
                        cnt_reg  <= '0;
                    end
                end
                isqc_pkg::ST_RDOUT: if (out_free) begin
                    // read data valid now; advance head and report
                    head_reg[srv_mv] <= wrap_inc(head_reg[srv_mv]);
                    cnt_reg   <= cnt_reg + 4'd1;
                    ov_reg    <= 1'b1;
                    okind_reg <= isqc_pkg::KIND_DEPARTURE;
                    oid_reg   <= rd_data[31:16];
                    omv_reg   <= srv_mv;
                    oacc_reg  <= 1'b0;
                    ocnt_reg  <= occ(wrap_inc(head_reg[srv_mv]), tail_reg[srv_mv]);
                    owait_reg <= now_reg - rd_data[15:0];
                    opc_reg   <= 1'b0;
                    olast_reg <= 1'b0;
                end
                isqc_pkg::ST_STAT: if (out_free) begin
                    ov_reg    <= 1'b1;
                    okind_reg <= isqc_pkg::KIND_STATUS;
                    oid_reg   <= '0;
                    omv_reg   <= '0;
                    oacc_reg  <= 1'b0;
                    ocnt_reg  <= '0;
                    owait_reg <= '0;
                    opc_reg   <= chg_reg;
                    olast_reg <= 1'b1;
                    now_reg   <= now_reg + 16'd1;
                    if (chg_reg) begin
                        axis_reg  <= ~axis_reg;
                        ptick_reg <= '0;
                    end else begin
                        ptick_reg <= ptick_reg + 10'd1;
                        // countdown lands after the status snapshot below
                        rem_reg[0] <= rem_dec[0];
                        rem_reg[1] <= rem_dec[1];
                    end
                end
                isqc_pkg::ST_OUT: ;
                default: ;
            endcase
        end
    end

    // status reports lights before the countdown
    logic [1:0] sl0, sl1;
    logic [9:0] sr0, sr1;
    always_ff @(posedge aclk) begin
        if (state_reg == isqc_pkg::ST_STAT && out_free) begin
            sl0 <= light_reg[0];
            sl1 <= light_reg[1];
            sr0 <= rem_reg[0];
            sr1 <= rem_reg[1];
        end
    end

    assign m_valid        = ov_reg;
    assign m_kind         = okind_reg;
    assign m_vehicle_id   = oid_reg;
    assign m_movement     = omv_reg;
    assign m_accepted     = oacc_reg;
    assign m_queue_count  = ocnt_reg;
    assign m_wait_time    = owait_reg;
    assign m_phase_change = opc_reg;
    assign m_last         = olast_reg;
    logic is_stat;
    assign is_stat        = okind_reg == isqc_pkg::KIND_STATUS;
    assign m_ns_light     = is_stat ? sl0 : 2'd0;
    assign m_ew_light     = is_stat ? sl1 : 2'd0;
    assign m_ns_remaining = is_stat ? sr0 : 10'd0;
    assign m_ew_remaining = is_stat ? sr1 : 10'd0;

endmodule
